// ===== src/pso_pkg.sv =====
`timescale 1ns / 1ps
package pso_pkg;

  localparam int VALUE_BITS_DEF = 32;
  localparam int FRAC_COEF      = 14;
  localparam int OMEGA_BITS     = 15;
  localparam int GAIN_BITS      = 16;
  localparam int DRAW_BITS      = 16;
  localparam int COEF_BITS      = 17;   // unsigned coefficient plus sign bit

  localparam int APB_ADDR_BITS  = 4;
  localparam int APB_DATA_BITS  = 32;

  // register index codes, taken from paddr[3:2]
  localparam logic [1:0] REG_INERTIA  = 2'd0;
  localparam logic [1:0] REG_PERSONAL = 2'd1;
  localparam logic [1:0] REG_GLOBAL   = 2'd2;

  localparam logic [OMEGA_BITS-1:0] INERTIA_RST  = 15'd8192;
  localparam logic [GAIN_BITS-1:0]  PERSONAL_RST = 16'd32768;
  localparam logic [GAIN_BITS-1:0]  GLOBAL_RST   = 16'd32768;

  typedef struct packed {
    logic [OMEGA_BITS-1:0] inertia_weight;
    logic [GAIN_BITS-1:0]  personal_gain;
    logic [GAIN_BITS-1:0]  global_gain;
  } pso_gains_t;

endpackage

// ===== src/pso_if.sv =====
`timescale 1ns / 1ps
interface pso_in_if #(parameter int W = 32);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] position;
  logic signed [W-1:0] velocity;
  logic signed [W-1:0] personal_best;
  logic signed [W-1:0] global_best;
  logic [15:0]         rand_personal;
  logic [15:0]         rand_global;
  logic signed [W-1:0] lower_bound;
  logic signed [W-1:0] upper_bound;
  logic [W-2:0]        grid_step;

  modport source (output valid, position, velocity, personal_best, global_best,
                  rand_personal, rand_global, lower_bound, upper_bound, grid_step,
                  input ready);
  modport sink   (input valid, position, velocity, personal_best, global_best,
                  rand_personal, rand_global, lower_bound, upper_bound, grid_step,
                  output ready);
endinterface

interface pso_out_if #(parameter int W = 32);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] new_velocity;
  logic signed [W-1:0] new_position;
  logic                saturated;

  modport source (output valid, new_velocity, new_position, saturated, input ready);
  modport sink   (input valid, new_velocity, new_position, saturated, output ready);
endinterface

// ===== src/pso_arith.sv =====
`timescale 1ns / 1ps
module pso_arith #(
  parameter int W = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_vld,
  input  logic signed [W-1:0]   position,
  input  logic signed [W-1:0]   velocity,
  input  logic signed [W-1:0]   personal_best,
  input  logic signed [W-1:0]   global_best,
  input  logic [15:0]           rand_personal,
  input  logic [15:0]           rand_global,
  input  logic signed [W-1:0]   lower_bound,
  input  logic signed [W-1:0]   upper_bound,
  input  logic [W-2:0]          grid_step,
  input  pso_pkg::pso_gains_t   gains,
  output logic                  out_vld,
  output logic signed [W-1:0]   out_nv,
  output logic signed [W-1:0]   out_np,
  output logic [W-2:0]          out_step,
  output logic                  out_sat
);
  import pso_pkg::*;

  localparam int PW = W + COEF_BITS;
  localparam logic signed [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};

  function automatic logic [W:0] sat_sum(input logic signed [W:0] s);
    logic [W:0] r;
    begin
      r = {1'b0, s[W-1:0]};
      if (s[W] != s[W-1]) begin
        r = {1'b1, (s[W] ? VMIN : VMAX)};
      end
      return r;
    end
  endfunction

  function automatic logic [W:0] shift_sat(input logic signed [PW-1:0] p);
    logic signed [PW-FRAC_COEF-1:0] s;
    logic [W:0] r;
    begin
      s = p[PW-1:FRAC_COEF];
      r = {1'b0, s[W-1:0]};
      if (s[PW-FRAC_COEF-1:W-1] != {(PW-FRAC_COEF-W+1){s[W-1]}}) begin
        r = {1'b1, (s[PW-FRAC_COEF-1] ? VMIN : VMAX)};
      end
      return r;
    end
  endfunction

  // stage 1: differences and random coefficients
  logic                 vld1, sat1;
  logic signed [W-1:0]  x1, v1, lb1, ub1, dp1, dg1;
  logic [W-2:0]         st1;
  logic [15:0]          cp1, cg1;
  logic [W:0]           dp_c, dg_c;
  logic [31:0]          cp_full, cg_full;

  assign dp_c = sat_sum({personal_best[W-1], personal_best} - {position[W-1], position});
  assign dg_c = sat_sum({global_best[W-1], global_best} - {position[W-1], position});
  assign cp_full = gains.personal_gain * rand_personal;
  assign cg_full = gains.global_gain * rand_global;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
    end else if (en) begin
      vld1 <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x1  <= position;
      v1  <= velocity;
      lb1 <= lower_bound;
      ub1 <= upper_bound;
      st1 <= grid_step;
      dp1 <= dp_c[W-1:0];
      dg1 <= dg_c[W-1:0];
      sat1 <= dp_c[W] | dg_c[W];
      cp1 <= cp_full[31:16];
      cg1 <= cg_full[31:16];
    end
  end

  // stage 2: the three products
  logic                 vld2, sat2;
  logic signed [W-1:0]  x2, lb2, ub2;
  logic [W-2:0]         st2;
  logic signed [PW-1:0] pv2, pp2, pg2;
  logic signed [COEF_BITS-1:0] om_s, cp_s, cg_s;

  assign om_s = {{(COEF_BITS-OMEGA_BITS){1'b0}}, gains.inertia_weight};
  assign cp_s = {1'b0, cp1};
  assign cg_s = {1'b0, cg1};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld2 <= 1'b0;
    end else if (en) begin
      vld2 <= vld1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x2  <= x1;
      lb2 <= lb1;
      ub2 <= ub1;
      st2 <= st1;
      sat2 <= sat1;
      pv2 <= PW'(v1 * om_s);
      pp2 <= PW'(dp1 * cp_s);
      pg2 <= PW'(dg1 * cg_s);
    end
  end

  // stage 3: floor shift, saturate, inertia plus personal
  logic                 vld3, sat3;
  logic signed [W-1:0]  x3, lb3, ub3, a3, tg3;
  logic [W-2:0]         st3;
  logic [W:0]           tv_c, tp_c, tg_c, a_c;

  assign tv_c = shift_sat(pv2);
  assign tp_c = shift_sat(pp2);
  assign tg_c = shift_sat(pg2);
  assign a_c  = sat_sum({tv_c[W-1], tv_c[W-1:0]} + {tp_c[W-1], tp_c[W-1:0]});

  always_ff @(posedge clk) begin
    if (rst) begin
      vld3 <= 1'b0;
    end else if (en) begin
      vld3 <= vld2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x3  <= x2;
      lb3 <= lb2;
      ub3 <= ub2;
      st3 <= st2;
      a3  <= a_c[W-1:0];
      tg3 <= tg_c[W-1:0];
      sat3 <= sat2 | tv_c[W] | tp_c[W] | tg_c[W] | a_c[W];
    end
  end

  // stage 4: add global term
  logic                 vld4, sat4;
  logic signed [W-1:0]  x4, lb4, ub4, nv4;
  logic [W-2:0]         st4;
  logic [W:0]           nv_c;

  assign nv_c = sat_sum({a3[W-1], a3} + {tg3[W-1], tg3});

  always_ff @(posedge clk) begin
    if (rst) begin
      vld4 <= 1'b0;
    end else if (en) begin
      vld4 <= vld3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x4  <= x3;
      lb4 <= lb3;
      ub4 <= ub3;
      st4 <= st3;
      nv4 <= nv_c[W-1:0];
      sat4 <= sat3 | nv_c[W];
    end
  end

  // stage 5: move and clamp, upper bound first so the lower one wins
  logic [W:0]          np_c;
  logic signed [W-1:0] np_u, np_l;

  assign np_c = sat_sum({x4[W-1], x4} + {nv4[W-1], nv4});
  always_comb begin
    np_u = ($signed(np_c[W-1:0]) > ub4) ? ub4 : np_c[W-1:0];
    np_l = (np_u < lb4) ? lb4 : np_u;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= vld4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_nv   <= nv4;
      out_np   <= np_l;
      out_step <= st4;
      out_sat  <= sat4 | np_c[W];
    end
  end

endmodule

// ===== src/pso_grid.sv =====
`timescale 1ns / 1ps
module pso_grid #(
  parameter int W = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_vld,
  input  logic signed [W-1:0]  in_nv,
  input  logic signed [W-1:0]  in_np,
  input  logic [W-2:0]         in_step,
  input  logic                 in_sat,
  output logic                 out_vld,
  output logic signed [W-1:0]  out_nv,
  output logic signed [W-1:0]  out_np,
  output logic                 out_sat
);
  import pso_pkg::*;

  localparam logic signed [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};

  // restoring remainder, one quotient bit per stage
  logic               vld [W+1];
  logic               sat [W+1];
  logic signed [W-1:0] nv [W+1];
  logic signed [W-1:0] np [W+1];
  logic [W-2:0]       stp [W+1];
  logic [W-1:0]       mag [W+1];
  logic [W-2:0]       rem [W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sat[0] <= in_sat;
      nv[0]  <= in_nv;
      np[0]  <= in_np;
      stp[0] <= in_step;
      mag[0] <= in_np[W-1] ? W'(-in_np) : in_np;
      rem[0] <= '0;
    end
  end

  for (genvar k = 0; k < W; k++) begin : g_step
    logic [W-1:0] trial;
    logic         fits;

    assign trial = {rem[k], mag[k][W-1]};
    assign fits  = trial >= {1'b0, stp[k]};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sat[k+1] <= sat[k];
        nv[k+1]  <= nv[k];
        np[k+1]  <= np[k];
        stp[k+1] <= stp[k];
        mag[k+1] <= {mag[k][W-2:0], 1'b0};
        rem[k+1] <= fits ? (W-1)'(trial - {1'b0, stp[k]}) : trial[W-2:0];
      end
    end
  end

  // fold remainder onto the floor side for negative positions
  logic                vld_r, sat_r, zero_r;
  logic signed [W-1:0] nv_r, np_r;
  logic [W-2:0]        fold_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld[W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sat_r  <= sat[W];
      nv_r   <= nv[W];
      np_r   <= np[W];
      zero_r <= stp[W] == '0;
      fold_r <= (np[W][W-1] && rem[W] != '0) ? stp[W] - rem[W] : rem[W];
    end
  end

  // subtract, saturating at the bottom of the range
  logic [W:0] diff;
  assign diff = {np_r[W-1], np_r} - {2'b00, fold_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_nv <= nv_r;
      if (zero_r) begin
        out_np  <= np_r;
        out_sat <= sat_r;
      end else if (diff[W] != diff[W-1]) begin
        out_np  <= VMIN;
        out_sat <= 1'b1;
      end else begin
        out_np  <= diff[W-1:0];
        out_sat <= sat_r;
      end
    end
  end

endmodule

// ===== src/pso_particle_update_top.sv =====
`timescale 1ns / 1ps
// Channel  Dir  Role                 Payload
// req      in   one particle dim     position velocity personal_best global_best
//                                    rand_personal rand_global lower/upper_bound grid_step
// rsp      out  updated dimension    new_velocity new_position saturated
// apb      in   gain registers       inertia_weight, personal_gain, global_gain
//
// One transfer per cycle in and out while rsp is not stalled. The pipeline
// consists of five arithmetic stages, a load stage and one stage per bit of the
// grid remainder unit, a fold stage, a subtract stage and the output buffer.
// rst is synchronous; it empties the pipeline and loads the gain defaults.
// A stall on rsp freezes the whole pipe; the two-entry output buffer gives
// the registered req.ready, so nothing is dropped or repeated.
module pso_particle_update_top #(
  parameter int VALUE_BITS = pso_pkg::VALUE_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  pso_in_if.sink                             req,
  pso_out_if.source                          rsp,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [pso_pkg::APB_ADDR_BITS-1:0]  paddr,
  input  logic [pso_pkg::APB_DATA_BITS-1:0]  pwdata,
  output logic [pso_pkg::APB_DATA_BITS-1:0]  prdata,
  output logic                               pready
);
  import pso_pkg::*;

  localparam int W = VALUE_BITS;

  // gain registers
  pso_gains_t  gains;
  logic        wr_en;
  logic [1:0]  reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      gains.inertia_weight <= INERTIA_RST;
      gains.personal_gain  <= PERSONAL_RST;
      gains.global_gain    <= GLOBAL_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_INERTIA:  gains.inertia_weight <= pwdata[OMEGA_BITS-1:0];
        REG_PERSONAL: gains.personal_gain  <= pwdata[GAIN_BITS-1:0];
        REG_GLOBAL:   gains.global_gain    <= pwdata[GAIN_BITS-1:0];
        default: ;    // drop writes to unmapped addresses
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_INERTIA:  prdata = {{(APB_DATA_BITS-OMEGA_BITS){1'b0}}, gains.inertia_weight};
      REG_PERSONAL: prdata = {{(APB_DATA_BITS-GAIN_BITS){1'b0}}, gains.personal_gain};
      REG_GLOBAL:   prdata = {{(APB_DATA_BITS-GAIN_BITS){1'b0}}, gains.global_gain};
      default:      prdata = '0;
    endcase
  end

  // pipeline advances whenever the output buffer has room
  logic [1:0] cnt;
  logic       en;

  assign en        = cnt != 2'd2;
  assign req.ready = en;

  logic                a_vld, a_sat;
  logic signed [W-1:0] a_nv, a_np;
  logic [W-2:0]        a_step;

  pso_arith #(.W(W)) u_arith (
    .clk           (clk),
    .rst           (rst),
    .en            (en),
    .in_vld        (req.valid),
    .position      (req.position),
    .velocity      (req.velocity),
    .personal_best (req.personal_best),
    .global_best   (req.global_best),
    .rand_personal (req.rand_personal),
    .rand_global   (req.rand_global),
    .lower_bound   (req.lower_bound),
    .upper_bound   (req.upper_bound),
    .grid_step     (req.grid_step),
    .gains         (gains),
    .out_vld       (a_vld),
    .out_nv        (a_nv),
    .out_np        (a_np),
    .out_step      (a_step),
    .out_sat       (a_sat)
  );

  logic                g_vld, g_sat;
  logic signed [W-1:0] g_nv, g_np;

  pso_grid #(.W(W)) u_grid (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (a_vld),
    .in_nv   (a_nv),
    .in_np   (a_np),
    .in_step (a_step),
    .in_sat  (a_sat),
    .out_vld (g_vld),
    .out_nv  (g_nv),
    .out_np  (g_np),
    .out_sat (g_sat)
  );

  // two-entry output buffer: head drives rsp, spare catches the item in flight
  logic                push, pop;
  logic signed [W-1:0] head_nv, head_np, spare_nv, spare_np;
  logic                head_sat, spare_sat;

  assign push = en & g_vld;
  assign pop  = rsp.valid & rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push && (cnt == 2'd0 || (cnt == 2'd1 && pop))) begin
      head_nv  <= g_nv;
      head_np  <= g_np;
      head_sat <= g_sat;
    end else if (pop && cnt == 2'd2) begin
      head_nv  <= spare_nv;
      head_np  <= spare_np;
      head_sat <= spare_sat;
    end
    if (push && cnt == 2'd1 && !pop) begin
      spare_nv  <= g_nv;
      spare_np  <= g_np;
      spare_sat <= g_sat;
    end
  end

  assign rsp.valid        = cnt != 2'd0;
  assign rsp.new_velocity = head_nv;
  assign rsp.new_position = head_np;
  assign rsp.saturated    = head_sat;

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk) disable iff (rst) cnt != 2'd3)
    else $error("output buffer count out of range");
  a_full_stall: assert property (@(posedge clk) disable iff (rst)
      (cnt == 2'd2) |-> !req.ready)
    else $error("input accepted while output buffer is full");
  a_push_shows: assert property (@(posedge clk) disable iff (rst)
      (push && cnt == 2'd0) |=> rsp.valid)
    else $error("pushed result not presented");
  a_hold_full: assert property (@(posedge clk) disable iff (rst)
      (cnt == 2'd2 && !pop) |=> (cnt == 2'd2))
    else $error("buffered result lost during stall");
`endif

endmodule
